// File: src/pnc_pkg.sv
// Shared constants, codes and types of the positive neighbor count window.
`timescale 1ns / 1ps

package pnc_pkg;

  // Frame limits and pixel format.
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIXEL_BITS = 16;

  // Field and counter widths.
  localparam int W_WID  = 8;                         // frame_width register
  localparam int W_HGT  = 11;                        // frame_height register
  localparam int W_COL  = $clog2(MAX_WIDTH);         // column index
  localparam int W_ROW  = 10;                        // input row counter, out_row
  localparam int W_POS  = 17;                        // linear result position
  localparam int W_AREA = W_POS + 1;                 // width times height
  localparam int W_CNT  = 4;                         // neighbor count 0..8
  localparam int W_STEP = $clog2(W_POS);             // divider step counter

  localparam logic [W_STEP-1:0] DIV_LAST_STEP = W_STEP'(W_POS - 1);

  localparam logic [W_WID-1:0] WIDTH_RESET  = W_WID'(MAX_WIDTH);
  localparam logic [W_HGT-1:0] HEIGHT_RESET = W_HGT'(MAX_HEIGHT);
  localparam logic [W_AREA-1:0] AREA_RESET  = W_AREA'(MAX_WIDTH * MAX_HEIGHT);

  // Item command codes.
  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } pnc_cmd_t;

  // Register select, taken from address bit 2.
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } pnc_reg_t;

  // Status of the position divider.
  typedef struct packed {
    logic busy;
    logic done;
  } pnc_div_stat_t;

endpackage

// File: src/pnc_div.sv
// Bit-serial restoring divider that splits a linear position into row and column.
`timescale 1ns / 1ps

module pnc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pnc_pkg::W_POS-1:0]      dividend,
  input  logic [pnc_pkg::W_WID-1:0]      divisor,
  output pnc_pkg::pnc_div_stat_t         stat,
  output logic [pnc_pkg::W_POS-1:0]      quotient,
  output logic [pnc_pkg::W_WID-1:0]      remainder
);

  logic                          busy_r;
  logic                          done_r;
  logic [pnc_pkg::W_STEP-1:0]    step_r;
  logic [pnc_pkg::W_POS-1:0]     quo_r;
  logic [pnc_pkg::W_WID-1:0]     rem_r;

  logic [pnc_pkg::W_WID:0]       rem_sh;
  logic [pnc_pkg::W_WID:0]       rem_sub;
  logic                          fits;

  assign rem_sh  = {rem_r, quo_r[pnc_pkg::W_POS-1]};
  assign fits    = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == pnc_pkg::DIV_LAST_STEP) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // One quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[pnc_pkg::W_POS-2:0], fits};
      rem_r <= fits ? rem_sub[pnc_pkg::W_WID-1:0] : rem_sh[pnc_pkg::W_WID-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: src/positive_neighbor_count_3x3.sv
// Top level of the 3x3 positive neighbor count window.
`timescale 1ns / 1ps

// Pixels of a frame arrive in raster order, one item per clock, and for every pixel the
// block reports how many of its eight neighbors hold a strictly positive value, with
// neighbors outside the frame not counted. Each result lags its pixel by one row plus one
// pixel, so after the last pixel the source sends frame_width+1 flush items to drain the
// remaining results; the result of the frame's last pixel carries out_frame_last and
// returns the counters to frame start. Throughput is one item per clock: all work for an
// item is a single pass from the line store and window registers to the result register,
// and the line store is read one item ahead so its registered read never holds the stream.
// The input stalls only while a result waits on a stalled output, and after each
// configuration write, while the new product width*height is registered and the current
// result position is split into row and column by a bit-serial divider (one bit per
// cycle over the 17-bit position). A frame_width of 0 acts as 1 and a value above 128
// as 128; a frame_height of 0 acts as 1 and a value above 1024 as 1024. Registers sit at
// byte address 0 (frame_width) and 4 (frame_height).

module positive_neighbor_count_3x3 (
  input  logic                                clk,
  input  logic                                rst_n,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic signed [pnc_pkg::PIXEL_BITS-1:0] in_pixel_value,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pnc_pkg::W_CNT-1:0]           out_neighbor_count,
  output logic [pnc_pkg::W_ROW-1:0]           out_row,
  output logic [pnc_pkg::W_COL-1:0]           out_col,
  output logic                                out_frame_last,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  // Configuration registers and the values actually used.
  logic [pnc_pkg::W_WID-1:0]  width_r;
  logic [pnc_pkg::W_HGT-1:0]  height_r;
  logic [pnc_pkg::W_WID-1:0]  used_width;
  logic [pnc_pkg::W_HGT-1:0]  used_height;
  logic [pnc_pkg::W_AREA-1:0] area_r;
  logic                       cfg_wr;
  logic                       cfg_pend_r;

  // Stream state.
  logic [pnc_pkg::W_COL-1:0]  in_col_r;
  logic [pnc_pkg::W_ROW-1:0]  in_row_r;
  logic [pnc_pkg::W_POS-1:0]  pos_r;
  logic [pnc_pkg::W_POS-1:0]  orow_r;
  logic [pnc_pkg::W_COL-1:0]  ocol_r;
  logic [8:0]                 win_r;

  logic [pnc_pkg::W_COL-1:0]  in_col_nxt;
  logic [pnc_pkg::W_ROW-1:0]  in_row_nxt;
  logic [pnc_pkg::W_POS-1:0]  pos_nxt;
  logic [pnc_pkg::W_POS-1:0]  orow_nxt;
  logic [pnc_pkg::W_COL-1:0]  ocol_nxt;
  logic [8:0]                 win_nxt;

  // Line store: bit 1 holds the flag two rows back, bit 0 the flag one row back.
  logic [1:0]                     line_mem [pnc_pkg::MAX_WIDTH];
  logic [pnc_pkg::MAX_WIDTH-1:0]  line_vld_r;
  logic [1:0]                     rd_data_r;
  logic                           rd_vld_r;
  logic                           byp_r;
  logic [1:0]                     byp_data_r;
  logic [1:0]                     line_q;

  // Result register.
  logic                       out_valid_r;
  logic [pnc_pkg::W_CNT-1:0]  out_count_r;
  logic [pnc_pkg::W_ROW-1:0]  out_row_r;
  logic [pnc_pkg::W_COL-1:0]  out_col_r;
  logic                       out_last_r;

  // Divider that rebuilds row and column from the position after a configuration write.
  pnc_pkg::pnc_div_stat_t     div_stat;
  logic [pnc_pkg::W_POS-1:0]  div_quo;
  logic [pnc_pkg::W_WID-1:0]  div_rem;

  logic                       accept;
  logic                       flag;
  logic                       top;
  logic                       mid;
  logic                       emit;
  logic                       last;
  logic                       col_wrap;
  logic                       ocol_wrap;
  logic                       left_ok;
  logic                       right_ok;
  logic                       top_ok;
  logic                       bot_ok;
  logic [pnc_pkg::W_CNT-1:0]  count;

  // ---------------------------------------------------------------- configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= pnc_pkg::WIDTH_RESET;
      height_r   <= pnc_pkg::HEIGHT_RESET;
      cfg_pend_r <= 1'b0;
    end else begin
      cfg_pend_r <= cfg_wr;
      if (cfg_wr) begin
        unique case (pnc_pkg::pnc_reg_t'(paddr[2]))
          pnc_pkg::REG_WIDTH:  width_r  <= pwdata[pnc_pkg::W_WID-1:0];
          pnc_pkg::REG_HEIGHT: height_r <= pwdata[pnc_pkg::W_HGT-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (pnc_pkg::pnc_reg_t'(paddr[2]))
      pnc_pkg::REG_WIDTH:  prdata = {{(32-pnc_pkg::W_WID){1'b0}}, width_r};
      pnc_pkg::REG_HEIGHT: prdata = {{(32-pnc_pkg::W_HGT){1'b0}}, height_r};
      default:             prdata = '0;
    endcase
  end

  // Out-of-range register values are clamped.
  always_comb begin
    if (width_r == '0) begin
      used_width = pnc_pkg::W_WID'(1);
    end else if (width_r > pnc_pkg::WIDTH_RESET) begin
      used_width = pnc_pkg::WIDTH_RESET;
    end else begin
      used_width = width_r;
    end
    if (height_r == '0) begin
      used_height = pnc_pkg::W_HGT'(1);
    end else if (height_r > pnc_pkg::HEIGHT_RESET) begin
      used_height = pnc_pkg::HEIGHT_RESET;
    end else begin
      used_height = height_r;
    end
  end

  // The frame area is registered from the clamped width and height; after a write it settles while input is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r <= pnc_pkg::AREA_RESET;
    end else begin
      area_r <= {{(pnc_pkg::W_AREA-pnc_pkg::W_WID){1'b0}}, used_width} *
                {{(pnc_pkg::W_AREA-pnc_pkg::W_HGT){1'b0}}, used_height};
    end
  end

  pnc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cfg_pend_r),
    .dividend  (pos_r),
    .divisor   (used_width),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // ---------------------------------------------------------------- handshake
  assign in_stall = cfg_pend_r || div_stat.busy || div_stat.done ||
                    (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------- single pass
  // A flush item enters the window like a pixel that is not positive.
  assign flag = (in_command == pnc_pkg::CMD_PIXEL) && (in_pixel_value != '0) &&
                !in_pixel_value[pnc_pkg::PIXEL_BITS-1];

  // The column's two older flags were fetched when the previous item was accepted.
  assign line_q = byp_r ? byp_data_r : (rd_vld_r ? rd_data_r : 2'b00);
  assign top    = line_q[1];
  assign mid    = line_q[0];

  // The newest column enters at the right of the window.
  assign win_nxt = {flag, mid, top, win_r[8:3]};

  // Results begin once the window is one row plus one pixel behind the input.
  assign emit = (pos_r != '0) || (in_row_r >= pnc_pkg::W_ROW'(2)) ||
                ((in_row_r == pnc_pkg::W_ROW'(1)) && (in_col_r != '0));

  assign col_wrap  = ({1'b0, in_col_r} + 1'b1) >= used_width;
  assign ocol_wrap = ({1'b0, ocol_r} + 1'b1) >= used_width;
  assign last      = ({1'b0, pos_r} + 1'b1) >= area_r;

  // Edge masking for the result pixel's neighbors.
  assign left_ok  = ocol_r != '0;
  assign right_ok = ({1'b0, ocol_r} + 1'b1) < used_width;
  assign top_ok   = orow_r != '0;
  assign bot_ok   = ({1'b0, orow_r} + 1'b1) <
                    {{(pnc_pkg::W_POS+1-pnc_pkg::W_HGT){1'b0}}, used_height};

  // Window bit k*3+t holds column k (left to right) and row t (top to bottom).
  always_comb begin
    logic col_ok;
    logic row_ok;
    count = '0;
    for (int k = 0; k < 3; k++) begin
      for (int t = 0; t < 3; t++) begin
        col_ok = (k == 0) ? left_ok : ((k == 2) ? right_ok : 1'b1);
        row_ok = (t == 0) ? top_ok : ((t == 2) ? bot_ok : 1'b1);
        if (!(k == 1 && t == 1) && col_ok && row_ok) begin
          count = count + pnc_pkg::W_CNT'(win_nxt[k*3+t]);
        end
      end
    end
  end

  // Next positions; the frame's last result returns everything to frame start.
  always_comb begin
    in_col_nxt = col_wrap ? '0 : in_col_r + 1'b1;
    in_row_nxt = col_wrap ? in_row_r + 1'b1 : in_row_r;
    pos_nxt    = pos_r;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    if (emit) begin
      if (last) begin
        in_col_nxt = '0;
        in_row_nxt = '0;
        pos_nxt    = '0;
        orow_nxt   = '0;
        ocol_nxt   = '0;
      end else begin
        pos_nxt  = pos_r + 1'b1;
        ocol_nxt = ocol_wrap ? '0 : ocol_r + 1'b1;
        orow_nxt = ocol_wrap ? orow_r + 1'b1 : orow_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
      pos_r    <= '0;
      orow_r   <= '0;
      ocol_r   <= '0;
      win_r    <= '0;
    end else if (accept) begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      pos_r    <= pos_nxt;
      orow_r   <= orow_nxt;
      ocol_r   <= ocol_nxt;
      win_r    <= win_nxt;
    end else if (div_stat.done) begin
      orow_r <= div_quo;
      ocol_r <= div_rem[pnc_pkg::W_COL-1:0];
    end
  end

  // ---------------------------------------------------------------- line store
  // Written at the current column, read ahead at the next item's column.
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[in_col_r] <= {mid, flag};
      rd_data_r          <= line_mem[in_col_nxt];
      byp_data_r         <= {mid, flag};
    end
  end

  // Entries never written read as zero; a read of the entry just written is bypassed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_vld_r <= '0;
      rd_vld_r   <= 1'b0;
      byp_r      <= 1'b0;
    end else if (accept) begin
      line_vld_r[in_col_r] <= 1'b1;
      rd_vld_r             <= line_vld_r[in_col_nxt];
      byp_r                <= in_col_nxt == in_col_r;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_count_r <= count;
      out_row_r   <= orow_r[pnc_pkg::W_ROW-1:0];
      out_col_r   <= ocol_r;
      out_last_r  <= last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_neighbor_count = out_count_r;
  assign out_row            = out_row_r;
  assign out_col            = out_col_r;
  assign out_frame_last     = out_last_r;

  // ---------------------------------------------------------------- assertions
  // No item may enter while row and column are being rebuilt.
  assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |-> !accept)
    else $error("item accepted during position rebuild");

  // Outside a rebuild the result column stays inside the used width.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!cfg_pend_r && !div_stat.busy && !div_stat.done) |-> ({1'b0, ocol_r} < used_width))
    else $error("result column beyond frame width");

  // Position zero means row and column are both zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!div_stat.busy && !div_stat.done && pos_r == '0) |-> (orow_r == '0 && ocol_r == '0))
    else $error("row or column out of step with position");

  // The frame's last result returns the stream to frame start.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit && last) |=> (pos_r == '0 && in_col_r == '0 && in_row_r == '0))
    else $error("counters not cleared after frame end");

endmodule
